// ===== rtl/rma_pkg.sv =====
// shared constants, types and control structs for the room allocator
// no dependencies; imported by every other file of the block
package rma_pkg;

	localparam int MaxRooms = 16;
	localparam int IdxW     = (MaxRooms > 1) ? $clog2(MaxRooms) : 1;
	localparam int RoomW    = 4;
	localparam int InTimeW  = 32;
	localparam int TimeW    = 40;
	localparam int CountW   = 32;
	localparam int CfgW     = 5;
	localparam int CfgReset = 16;

	typedef logic [IdxW-1:0]    idx_t;
	typedef logic [RoomW-1:0]   room_t;
	typedef logic [InTimeW-1:0] in_time_t;
	typedef logic [TimeW-1:0]   ftime_t;
	typedef logic [CountW-1:0]  count_t;
	typedef logic [CfgW-1:0]    cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_BEST,
		ST_EMIT
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic update;
		logic best;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/rma_in_if.sv =====
// input channel of the room allocator: one meeting per item
// depends on rma_pkg for field types
interface rma_in_if;
	import rma_pkg::*;

	logic     valid;
	logic     ready;
	in_time_t start_time;
	in_time_t end_time;
	logic     last_meeting;

	modport source (output valid, output start_time, output end_time, output last_meeting,
		input ready);
	modport sink (input valid, input start_time, input end_time, input last_meeting,
		output ready);
endinterface

// ===== rtl/rma_out_if.sv =====
// output channel of the room allocator: one result per meeting
// depends on rma_pkg for field types
interface rma_out_if;
	import rma_pkg::*;

	logic   valid;
	logic   ready;
	room_t  assigned_room;
	ftime_t finish_time;
	room_t  most_booked_room;
	logic   result_last;

	modport source (output valid, output assigned_room, output finish_time,
		output most_booked_room, output result_last, input ready);
	modport sink (input valid, input assigned_room, input finish_time,
		input most_booked_room, input result_last, output ready);
endinterface

// ===== rtl/rma_datapath.sv =====
// room state, scan registers, finish arithmetic and output register
// depends on rma_pkg and the two channel interfaces
module rma_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  rma_pkg::cfg_t   cfg_wdata,
	input  rma_pkg::cmd_t   cmd,
	output rma_pkg::status_t status,
	rma_in_if.sink          in_ch,
	rma_out_if.source       out_ch
);
	import rma_pkg::*;

	cfg_t     cfg_q;
	ftime_t   free_at_q [MaxRooms];
	count_t   book_q    [MaxRooms];
	idx_t     idx_q;
	logic     out_valid_q;

	in_time_t start_q;
	in_time_t end_q;
	in_time_t dur_q;
	logic     last_q;
	idx_t     rooms_m1_q;
	logic     found_q;
	idx_t     pick_q;
	ftime_t   min_q;
	idx_t     min_idx_q;
	count_t   best_cnt_q;
	idx_t     best_q;
	idx_t     room_q;
	ftime_t   fin_q;

	room_t    out_room_q;
	ftime_t   out_fin_q;
	room_t    out_best_q;
	logic     out_last_q;

	ftime_t         rd_free;
	count_t         rd_book;
	logic           first;
	logic           hit;
	idx_t           room_sel;
	logic [TimeW:0] delay_sum;
	ftime_t         fin;
	idx_t           rooms_m1_in;

	// clamp the room count to 1..MaxRooms
	always_comb begin
		if (cfg_q == '0) begin
			rooms_m1_in = '0;
		end else if (int'(cfg_q) > MaxRooms) begin
			rooms_m1_in = IdxW'(MaxRooms - 1);
		end else begin
			rooms_m1_in = IdxW'(cfg_q - cfg_t'(1));
		end
	end

	assign rd_free   = free_at_q[idx_q];
	assign rd_book   = book_q[idx_q];
	assign first     = (idx_q == '0);
	assign hit       = (rd_free <= ftime_t'(start_q));
	assign room_sel  = found_q ? pick_q : min_idx_q;
	assign delay_sum = {1'b0, min_q} + (TimeW+1)'(dur_q);

	always_comb begin
		if (found_q) begin
			fin = ftime_t'(end_q);
		end else if (delay_sum[TimeW]) begin
			fin = '1;
		end else begin
			fin = delay_sum[TimeW-1:0];
		end
	end

	assign status.scan_done = (idx_q == rooms_m1_q);
	assign status.last      = last_q;
	assign status.out_free  = !out_valid_q || out_ch.ready;

	assign in_ch.ready             = cmd.load;
	assign out_ch.valid            = out_valid_q;
	assign out_ch.assigned_room    = out_room_q;
	assign out_ch.finish_time      = out_fin_q;
	assign out_ch.most_booked_room = out_best_q;
	assign out_ch.result_last      = out_last_q;

	// control state and room arrays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= cfg_t'(CfgReset);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MaxRooms; i++) begin
				free_at_q[i] <= '0;
				book_q[i]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.load || cmd.update) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.best) begin
				idx_q <= status.scan_done ? '0 : idx_q + idx_t'(1);
			end
			if (cmd.update) begin
				free_at_q[room_sel] <= fin;
				if (book_q[room_sel] != '1) begin
					book_q[room_sel] <= book_q[room_sel] + count_t'(1);
				end
			end
			if (cmd.emit && last_q) begin
				for (int i = 0; i < MaxRooms; i++) begin
					free_at_q[i] <= '0;
					book_q[i]    <= '0;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q    <= in_ch.start_time;
			end_q      <= in_ch.end_time;
			dur_q      <= (in_ch.end_time > in_ch.start_time) ?
				in_ch.end_time - in_ch.start_time : '0;
			last_q     <= in_ch.last_meeting;
			rooms_m1_q <= rooms_m1_in;
		end
		if (cmd.scan) begin
			if (first) begin
				found_q <= hit;
				pick_q  <= idx_q;
			end else if (!found_q && hit) begin
				found_q <= 1'b1;
				pick_q  <= idx_q;
			end
			if (first || rd_free < min_q) begin
				min_q     <= rd_free;
				min_idx_q <= idx_q;
			end
		end
		if (cmd.update) begin
			room_q <= room_sel;
			fin_q  <= fin;
		end
		if (cmd.best) begin
			if (first || rd_book > best_cnt_q) begin
				best_cnt_q <= rd_book;
				best_q     <= idx_q;
			end
		end
		if (cmd.emit) begin
			out_room_q <= RoomW'(room_q);
			out_fin_q  <= fin_q;
			out_best_q <= last_q ? RoomW'(best_q) : '0;
			out_last_q <= last_q;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result loaded over an untaken result");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan || cmd.best) |-> idx_q <= rooms_m1_q)
		else $error("scan index beyond room count");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && last_q) |=> (free_at_q[0] == '0 && book_q[0] == '0))
		else $error("room state not cleared after last meeting");

endmodule

// ===== rtl/rma_ctrl.sv =====
// sequencing state machine: accept, scan, update, most-booked scan, emit
// depends on rma_pkg
module rma_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rma_pkg::status_t status,
	output rma_pkg::cmd_t    cmd
);
	import rma_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = status.last ? ST_BEST : ST_EMIT;
			end
			ST_BEST: begin
				if (status.scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load   = 1'b1;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_BEST:   cmd.best   = 1'b1;
			ST_EMIT:   cmd.emit   = status.out_free;
			default:   cmd        = '0;
		endcase
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && in_valid) |=> state_q == ST_SCAN)
		else $error("accepted item did not start a scan");

	a_update_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> !cmd.update)
		else $error("room update issued twice for one item");

endmodule

// ===== rtl/room_allocator_with_delay.sv =====
// room allocator: an item passes through accept, a scan of each room, update and emit;
// the last meeting of a set adds a second pass over every room for the most-booked room
// items are handled one at a time: the next item is accepted only after the previous one is emitted
// an item is accepted while the previous result still waits in the output register
// arst_n clears all room times and counts, sets room_count to 16 and empties the output
// room state is cleared again when the result of a last meeting is loaded for output
module room_allocator_with_delay (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  rma_pkg::cfg_t cfg_wdata,
	rma_in_if.sink        in_ch,
	rma_out_if.source     out_ch
);
	import rma_pkg::*;

	// command and status between controller and datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: idle accepts, then scan rooms, update, optional most-booked pass, emit
	rma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.status   (status),
		.cmd      (cmd)
	);

	// room arrays, scan registers, delay arithmetic and the output register
	rma_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule
